// ----- rtl/elsh_pkg.sv -----
// Shared types, sizes and constants for the Euclidean LSH hash core.
// Used by every module in rtl/; has no dependencies of its own.
package elsh_pkg;

    localparam int MAX_DIMS        = 64;
    localparam int MAX_PROJECTIONS = 16;
    localparam int DIM_W           = $clog2(MAX_DIMS);
    localparam int PROJ_W          = $clog2(MAX_PROJECTIONS);
    localparam int ACC_W           = 48;
    localparam int NUM_W           = ACC_W + 1;

    localparam logic [31:0] HASH_PRIME = 32'hFFFF_FFFB;

    typedef enum logic [1:0] {
        CMD_FEATURE    = 2'd0,
        CMD_LOAD_COEFF = 2'd1,
        CMD_LOAD_OFF   = 2'd2,
        CMD_LOAD_MUL   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_BUCKET_WIDTH = 2'd0,
        REG_DIMS_IN_USE  = 2'd1,
        REG_PROJ_IN_USE  = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_CAPTURE,
        S_FINISH
    } top_state_t;

    typedef enum logic [3:0] {
        F_IDLE,
        F_LOAD,
        F_DIV,
        F_FIX,
        F_RB,
        F_MUL,
        F_RED1,
        F_RED2,
        F_ACC
    } fin_state_t;

    typedef struct packed {
        logic mac_en;
        logic capture;
        logic shift;
    } cell_ctrl_t;

endpackage

// ----- rtl/elsh_cell.sv -----
// One projection cell: coefficient memory, dot accumulator, offset and multiplier,
// plus one stage of the result chain that drains toward cell 0. Depends on elsh_pkg.
module elsh_cell
    import elsh_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cell_ctrl_t              ctrl,
    input  logic                    coeff_we,
    input  logic                    off_we,
    input  logic                    mul_we,
    input  logic [DIM_W-1:0]        waddr,
    input  logic [31:0]             wdata,
    input  logic [DIM_W-1:0]        raddr,
    input  logic signed [15:0]      feat,
    input  logic signed [NUM_W-1:0] num_in,
    input  logic [31:0]             mul_in,
    output logic signed [NUM_W-1:0] num_out,
    output logic [31:0]             mul_out
);

    logic signed [15:0]      coeff_mem [MAX_DIMS];
    logic signed [15:0]      coeff_rd_reg;
    logic signed [31:0]      off_reg;
    logic [31:0]             mul_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [NUM_W-1:0] num_reg;
    logic [31:0]             mulc_reg;
    logic signed [31:0]      prod;

    always_ff @(posedge clk)
    begin
        if (coeff_we)
        begin
            coeff_mem[waddr] <= wdata[15:0];
        end
        coeff_rd_reg <= coeff_mem[raddr];
        if (off_we)
        begin
            off_reg <= wdata;
        end
        if (mul_we)
        begin
            mul_reg <= wdata;
        end
    end

    always_comb
    begin
        prod     = coeff_rd_reg * feat;
        acc_next = acc_reg;
        if (ctrl.capture)
        begin
            acc_next = '0;
        end
        else if (ctrl.mac_en)
        begin
            acc_next = acc_reg + ACC_W'(prod);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    // The chain loads every cell at once, then moves one projection toward cell 0 per shift.
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            num_reg  <= NUM_W'(acc_reg) + NUM_W'(off_reg);
            mulc_reg <= mul_reg;
        end
        else if (ctrl.shift)
        begin
            num_reg  <= num_in;
            mulc_reg <= mul_in;
        end
    end

    assign num_out = num_reg;
    assign mul_out = mulc_reg;

endmodule

// ----- rtl/elsh_finish.sv -----
// Bucket and hash unit: serial floor division, signed reduction mod 2^32-5,
// modular multiply and sum over the projections drained from the cell chain. Depends on elsh_pkg.
module elsh_finish
    import elsh_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    go,
    input  logic [PROJ_W:0]         np,
    input  logic [30:0]             width,
    input  logic signed [NUM_W-1:0] num,
    input  logic [31:0]             mul,
    output logic                    shift,
    output logic                    done,
    output logic [31:0]             hash
);

    localparam int QM_W  = NUM_W + 1;
    localparam int CNT_W = $clog2(NUM_W + 1);

    fin_state_t state_reg, state_next;

    logic [CNT_W-1:0]  cnt_reg;
    logic [PROJ_W:0]   pcnt_reg;
    logic              neg_reg;
    logic [NUM_W-1:0]  q_reg;
    logic [31:0]       rem_reg;
    logic [31:0]       mul_reg;
    logic [33:0]       t_reg;
    logic [31:0]       rb_reg;
    logic [31:0]       rm_reg;
    logic [63:0]       prod_reg;
    logic [34:0]       t1_reg;
    logic [31:0]       x_reg;
    logic [31:0]       h_reg;
    logic              done_reg;

    logic [31:0]       w_eff;
    logic [31:0]       r2;
    logic              bit_q;
    logic [QM_W-1:0]   qm;
    logic [33:0]       t_calc;
    logic [31:0]       r_red;
    logic [32:0]       t2;
    logic [32:0]       hsum;

    always_comb
    begin
        w_eff  = (width == '0) ? 32'd1 : {1'b0, width};
        r2     = {rem_reg[30:0], q_reg[NUM_W-1]};
        bit_q  = (r2 >= w_eff);
        qm     = QM_W'(q_reg) + QM_W'(neg_reg && (rem_reg != '0));
        // 2^32 is 5 modulo the prime, so the high part folds in with a factor of five.
        t_calc = 34'(qm[QM_W-1:32]) * 34'd5 + 34'(qm[31:0]);
        r_red  = (t_reg >= 34'(HASH_PRIME)) ? 32'(t_reg - 34'(HASH_PRIME)) : t_reg[31:0];
        t2     = 33'(t1_reg[34:32]) * 33'd5 + 33'(t1_reg[31:0]);
        hsum   = 33'(h_reg) + 33'(x_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        shift      = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (go)
                begin
                    state_next = F_LOAD;
                end
            end
            F_LOAD: state_next = F_DIV;
            F_DIV:
            begin
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    state_next = F_FIX;
                end
            end
            F_FIX:  state_next = F_RB;
            F_RB:   state_next = F_MUL;
            F_MUL:  state_next = F_RED1;
            F_RED1: state_next = F_RED2;
            F_RED2: state_next = F_ACC;
            F_ACC:
            begin
                if (pcnt_reg + 1'b1 >= np)
                begin
                    state_next = F_IDLE;
                end
                else
                begin
                    shift      = 1'b1;
                    state_next = F_LOAD;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            done_reg  <= 1'b0;
            pcnt_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == F_ACC) && (pcnt_reg + 1'b1 >= np);
            if (state_reg == F_IDLE)
            begin
                pcnt_reg <= '0;
            end
            else if (state_reg == F_ACC)
            begin
                pcnt_reg <= pcnt_reg + 1'b1;
            end
            if (state_reg == F_LOAD)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == F_DIV)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                h_reg <= '0;
            end
            F_LOAD:
            begin
                neg_reg <= num[NUM_W-1];
                q_reg   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
                rem_reg <= '0;
                mul_reg <= mul;
            end
            F_DIV:
            begin
                rem_reg <= bit_q ? (r2 - w_eff) : r2;
                q_reg   <= {q_reg[NUM_W-2:0], bit_q};
            end
            F_FIX:
            begin
                t_reg <= t_calc;
            end
            F_RB:
            begin
                rb_reg <= (neg_reg && (r_red != '0)) ? (HASH_PRIME - r_red) : r_red;
                rm_reg <= mul_reg[31] ? (HASH_PRIME + mul_reg) : mul_reg;
            end
            F_MUL:
            begin
                prod_reg <= 64'(rb_reg) * 64'(rm_reg);
            end
            F_RED1:
            begin
                t1_reg <= 35'(prod_reg[63:32]) * 35'd5 + 35'(prod_reg[31:0]);
            end
            F_RED2:
            begin
                x_reg <= (t2 >= 33'(HASH_PRIME)) ? 32'(t2 - 33'(HASH_PRIME)) : t2[31:0];
            end
            F_ACC:
            begin
                h_reg <= (hsum >= 33'(HASH_PRIME)) ? 32'(hsum - 33'(HASH_PRIME)) : hsum[31:0];
            end
            default:
            begin
                h_reg <= h_reg;
            end
        endcase
    end

    assign done = done_reg;
    assign hash = h_reg;

endmodule

// ----- rtl/euclidean_lsh_hash_core.sv -----
// Top level of the Euclidean LSH hash core: command decode, configuration
// registers, the row of projection cells and the hash unit. Depends on elsh_pkg.
// Load commands are taken while idle. A feature element is handled as a coefficient read, then a MAC
// in all cells at once. The last element of a vector then also runs the hash unit, whose
// time is set by the 49-step serial floor divider and the modular multiply per projection.
// hash_valid pulses for one cycle; the receiver cannot stall.
// Reset clears control, accumulators and count and sets configuration to defaults; tables are undefined until loaded.
module euclidean_lsh_hash_core
    import elsh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         command,
    input  logic [3:0]         proj_index,
    input  logic [5:0]         dim_index,
    input  logic signed [15:0] feature,
    input  logic signed [31:0] load_value,
    output logic               hash_valid,
    output logic [31:0]        lsh_hash,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    top_state_t state_reg, state_next;

    logic [30:0]         width_reg;
    logic [6:0]          dims_reg;
    logic [4:0]          projs_reg;
    logic [DIM_W:0]      count_reg;
    logic                end_reg;
    logic signed [15:0]  feat_reg;
    logic [DIM_W:0]      nd;
    logic [PROJ_W:0]     np;
    logic                accept;
    logic                cfg_we;
    logic                fin_go;
    logic                fin_shift;
    logic                fin_done;
    logic [31:0]         fin_hash;
    cell_ctrl_t          ctrl;

    logic signed [NUM_W-1:0] num_link [MAX_PROJECTIONS+1];
    logic [31:0]             mul_link [MAX_PROJECTIONS+1];

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_comb
    begin
        if (dims_reg == '0)
        begin
            nd = (DIM_W+1)'(1);
        end
        else if (32'(dims_reg) > 32'(MAX_DIMS))
        begin
            nd = (DIM_W+1)'(MAX_DIMS);
        end
        else
        begin
            nd = (DIM_W+1)'(dims_reg);
        end
        if (projs_reg == '0)
        begin
            np = (PROJ_W+1)'(1);
        end
        else if (32'(projs_reg) > 32'(MAX_PROJECTIONS))
        begin
            np = (PROJ_W+1)'(MAX_PROJECTIONS);
        end
        else
        begin
            np = (PROJ_W+1)'(projs_reg);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        ctrl.mac_en  = 1'b0;
        ctrl.capture = 1'b0;
        ctrl.shift   = fin_shift;
        fin_go       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd_t'(command) == CMD_FEATURE))
                begin
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                ctrl.mac_en = 1'b1;
                state_next  = end_reg ? S_CAPTURE : S_IDLE;
            end
            S_CAPTURE:
            begin
                ctrl.capture = 1'b1;
                fin_go       = 1'b1;
                state_next   = S_FINISH;
            end
            S_FINISH:
            begin
                if (fin_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            width_reg <= 31'd1048576;
            dims_reg  <= 7'd64;
            projs_reg <= 5'd16;
            count_reg <= '0;
            end_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_BUCKET_WIDTH: width_reg <= cfg_data[30:0];
                    REG_DIMS_IN_USE:  dims_reg  <= cfg_data[6:0];
                    REG_PROJ_IN_USE:  projs_reg <= cfg_data[4:0];
                    default:          width_reg <= width_reg;
                endcase
            end
            if (accept && (cmd_t'(command) == CMD_FEATURE))
            begin
                count_reg <= count_reg + 1'b1;
                end_reg   <= (count_reg + 1'b1 >= nd);
            end
            else if (state_reg == S_CAPTURE)
            begin
                count_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            feat_reg <= feature;
        end
    end

    assign num_link[MAX_PROJECTIONS] = '0;
    assign mul_link[MAX_PROJECTIONS] = '0;

    for (genvar i = 0; i < MAX_PROJECTIONS; i++)
    begin : g_cell
        logic sel;
        assign sel = accept && (32'(proj_index) == i);

        elsh_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .coeff_we (sel && (cmd_t'(command) == CMD_LOAD_COEFF)
                       && (32'(dim_index) < 32'(MAX_DIMS))),
            .off_we   (sel && (cmd_t'(command) == CMD_LOAD_OFF)),
            .mul_we   (sel && (cmd_t'(command) == CMD_LOAD_MUL)),
            .waddr    (DIM_W'(dim_index)),
            .wdata    (load_value),
            .raddr    (count_reg[DIM_W-1:0]),
            .feat     (feat_reg),
            .num_in   (num_link[i+1]),
            .mul_in   (mul_link[i+1]),
            .num_out  (num_link[i]),
            .mul_out  (mul_link[i])
        );
    end

    elsh_finish u_finish (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (fin_go),
        .np    (np),
        .width (width_reg),
        .num   (num_link[0]),
        .mul   (mul_link[0]),
        .shift (fin_shift),
        .done  (fin_done),
        .hash  (fin_hash)
    );

    assign hash_valid = fin_done;
    assign lsh_hash   = fin_hash;

endmodule
